/* sv/scbo_pkg.sv */
// Shared types and codes for the sliding correlation best-offset block.
// No dependencies; design files use scoped names, testbench files import it.
`default_nettype none

package scbo_pkg;

    typedef logic [1:0]  t_base;
    typedef logic [15:0] t_offset;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_NONE  = 2'd2
    } t_status;

    // Control tag that rides along with a window through the scoring stages.
    typedef struct packed {
        logic    last;       // item closes the reference
        logic    score;      // a full window ends on this item
        logic    short_ref;  // fewer bases than the window seen so far
        t_offset start;      // window start, masked to 16 bits
    } t_tag;

endpackage

`default_nettype wire

/* sv/scbo_if.sv */
// Valid/ready channels: reference bases in, best-offset reports out.
// Depends on scbo_pkg for payload types.
`default_nettype none

interface scbo_in_if;
    logic                 valid;
    logic                 ready;
    scbo_pkg::t_base      base;
    logic                 last;

    modport source (output valid, output base, output last, input ready);
    modport sink   (input valid, input base, input last, output ready);
endinterface

interface scbo_out_if;
    logic                 valid;
    logic                 ready;
    scbo_pkg::t_offset    best_offset;
    scbo_pkg::t_status    status;

    modport source (output valid, output best_offset, output status, input ready);
    modport sink   (input valid, input best_offset, input status, output ready);
endinterface

`default_nettype wire

/* sv/scbo_cell.sv */
// One correlation cell: adds bases and base products to the partial sums
// from its left neighbor and registers them. Depends on scbo_pkg.
`default_nettype none

module scbo_cell #(
    parameter int SX_W = 4,
    parameter int SQ_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire scbo_pkg::t_base   i_x,
    input  wire scbo_pkg::t_base   i_y,
    input  wire logic [SX_W-1:0]   i_sx,
    input  wire logic [SQ_W-1:0]   i_sxx,
    input  wire logic [SX_W-1:0]   i_sy,
    input  wire logic [SQ_W-1:0]   i_sxy,
    output logic      [SX_W-1:0]   o_sx,
    output logic      [SQ_W-1:0]   o_sxx,
    output logic      [SX_W-1:0]   o_sy,
    output logic      [SQ_W-1:0]   o_sxy
);

    logic [3:0] w_xx;
    logic [3:0] w_xy;

    assign w_xx = {2'b00, i_x} * {2'b00, i_x};
    assign w_xy = {2'b00, i_x} * {2'b00, i_y};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sx  <= i_sx  + SX_W'(i_x);
            o_sxx <= i_sxx + SQ_W'(w_xx);
            o_sy  <= i_sy  + SX_W'(i_y);
            o_sxy <= i_sxy + SQ_W'(w_xy);
        end
    end

endmodule

`default_nettype wire

/* sv/scbo_score.sv */
// Scoring pipeline: covariance and spread, squared covariance, then the
// cross-multiplied compare against the kept best and the report. Uses scbo_pkg.
`default_nettype none

module scbo_score #(
    parameter int WINDOW = 3,
    parameter int SX_W   = 4,
    parameter int SQ_W   = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_vld,
    input  wire scbo_pkg::t_tag    i_tag,
    input  wire logic [SX_W-1:0]   i_sx,
    input  wire logic [SQ_W-1:0]   i_sxx,
    input  wire logic [SX_W-1:0]   i_sy,
    input  wire logic [SQ_W-1:0]   i_sxy,
    output logic                   o_rep_vld,
    output scbo_pkg::t_offset      o_rep_offset,
    output scbo_pkg::t_status      o_rep_status
);

    // |C| and X are both bounded by 9*WINDOW^2
    localparam int CM_W = $clog2(9 * WINDOW * WINDOW + 1);
    localparam int C2_W = 2 * CM_W;
    localparam int PR_W = C2_W + CM_W;

    // stage B: C = n*Sxy - Sx*Sy, X = n*Sxx - Sx*Sx
    logic [CM_W-1:0]        w_nxy, w_sxsy, w_nxx, w_sxsx;
    logic signed [CM_W:0]   w_c;
    logic [CM_W-1:0]        w_x;

    logic                   r_b_vld;
    scbo_pkg::t_tag         r_b_tag;
    logic signed [CM_W:0]   r_b_c;
    logic [CM_W-1:0]        r_b_x;

    // stage C: C^2
    logic [CM_W-1:0]        w_c_abs;
    logic [C2_W-1:0]        w_c2;
    scbo_pkg::t_tag         w_c_tag;

    logic                   r_c_vld;
    scbo_pkg::t_tag         r_c_tag;
    logic [C2_W-1:0]        r_c_c2;
    logic [CM_W-1:0]        r_c_x;

    // stage D: compare against the best so far
    logic                   r_found;
    logic [C2_W-1:0]        r_best_c2;
    logic [CM_W-1:0]        r_best_x;
    scbo_pkg::t_offset      r_best_start;

    logic [PR_W-1:0]        w_lhs, w_rhs;
    logic                   w_upd;
    logic                   w_found_now;
    scbo_pkg::t_offset      w_start_now;

    assign w_nxy  = CM_W'(WINDOW) * CM_W'(i_sxy);
    assign w_sxsy = CM_W'(i_sx) * CM_W'(i_sy);
    assign w_nxx  = CM_W'(WINDOW) * CM_W'(i_sxx);
    assign w_sxsx = CM_W'(i_sx) * CM_W'(i_sx);
    assign w_c    = $signed({1'b0, w_nxy}) - $signed({1'b0, w_sxsy});
    assign w_x    = w_nxx - w_sxsx;   // never negative

    assign w_c_abs = r_b_c[CM_W] ? CM_W'(-r_b_c) : r_b_c[CM_W-1:0];
    assign w_c2    = C2_W'(w_c_abs) * C2_W'(w_c_abs);

    // zero covariance or a flat window scores zero; a flat template gives C = 0
    always_comb begin
        w_c_tag       = r_b_tag;
        w_c_tag.score = r_b_tag.score && (r_b_c != '0) && (r_b_x != '0);
    end

    assign w_lhs = PR_W'(r_c_c2) * PR_W'(r_best_x);
    assign w_rhs = PR_W'(r_best_c2) * PR_W'(r_c_x);
    assign w_upd = r_c_vld && r_c_tag.score && (!r_found || (w_lhs > w_rhs));

    assign w_found_now = r_found || w_upd;
    assign w_start_now = w_upd ? r_c_tag.start : r_best_start;

    assign o_rep_vld = i_adv && r_c_vld && r_c_tag.last;

    always_comb begin
        if (r_c_tag.short_ref) begin
            o_rep_status = scbo_pkg::STATUS_SHORT;
            o_rep_offset = '0;
        end else if (!w_found_now) begin
            o_rep_status = scbo_pkg::STATUS_NONE;
            o_rep_offset = '0;
        end else begin
            o_rep_status = scbo_pkg::STATUS_OK;
            o_rep_offset = w_start_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_found <= 1'b0;
        end else if (i_adv) begin
            r_b_vld <= i_vld;
            r_c_vld <= r_b_vld;
            if (r_c_vld) begin
                if (r_c_tag.last) begin
                    r_found <= 1'b0;
                end else if (w_upd) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_tag <= i_tag;
            r_b_c   <= w_c;
            r_b_x   <= w_x;
            r_c_tag <= w_c_tag;
            r_c_c2  <= w_c2;
            r_c_x   <= r_b_x;
            if (w_upd) begin
                r_best_c2    <= r_c_c2;
                r_best_x     <= r_c_x;
                r_best_start <= r_c_tag.start;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/sliding_correlation_best_offset.sv */
// Sliding correlation best offset: top level with the cell chain, the base
// counter and the report register. Depends on scbo_pkg, scbo_if, scbo_cell, scbo_score.
//
// Usage:
//   i_ref  (valid/ready sink): one reference base per item, last marks the end.
//   o_res  (valid/ready source): one report per last item, best_offset + status.
//   i_cfg_we / i_cfg_data: template write, 2 bits per base, first base lowest.
// Throughput: one base per cycle while o_res is not stalled and no replay runs.
// A report passes the stage A, B and C registers and the output register.
// After each template write the chain replays the held bases with the new
//   template: ready stays low until the replay is done.
// Reset (sync, active low) clears the template, counter and best; no replay.
// When the receiver stalls with a report waiting, the whole pipe holds and
//   ready drops until the report is taken.
// A chain of WINDOW cells builds the window sums as bases arrive (transposed
//   correlator); the scoring pipe squares the covariance and compares by
//   cross-multiplication, keeping the first strictly best window.
// Bases beyond MAX_REFERENCE are not scored; the count saturates.
`default_nettype none

module sliding_correlation_best_offset #(
    parameter int WINDOW        = 3,
    parameter int MAX_REFERENCE = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    scbo_in_if.sink                    i_ref,
    scbo_out_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [2*WINDOW-1:0]   i_cfg_data
);

    localparam int SX_W  = $clog2(3 * WINDOW + 1);
    localparam int SQ_W  = $clog2(9 * WINDOW + 1);
    localparam int CNT_W = $clog2(MAX_REFERENCE + 1);
    localparam int REP_W = $clog2(WINDOW);

    // configuration and replay
    logic [2*WINDOW-1:0]   r_template;
    logic [REP_W-1:0]      r_rep_cnt;
    logic                  w_rep;

    // last WINDOW-1 bases, kept so the chain can be rebuilt
    scbo_pkg::t_base       r_win [0:WINDOW-2];

    // stream control
    logic [CNT_W-1:0]      r_seen;
    logic [CNT_W-1:0]      w_seen_new;
    logic                  w_eval;
    logic                  w_adv;
    logic                  w_acc;
    logic                  w_feed;
    scbo_pkg::t_base       w_x;
    scbo_pkg::t_tag        w_tag;

    // stage A, aligned with the cell registers
    logic                  r_a_vld;
    scbo_pkg::t_tag        r_a_tag;

    // partial sums between neighboring cells
    logic [SX_W-1:0]       w_sx  [0:WINDOW];
    logic [SQ_W-1:0]       w_sxx [0:WINDOW];
    logic [SX_W-1:0]       w_sy  [0:WINDOW];
    logic [SQ_W-1:0]       w_sxy [0:WINDOW];

    // report
    logic                  w_rep_vld;
    scbo_pkg::t_offset     w_rep_offset;
    scbo_pkg::t_status     w_rep_status;
    logic                  r_out_vld;
    scbo_pkg::t_offset     r_out_offset;
    scbo_pkg::t_status     r_out_status;

    // pipe moves unless a report is waiting and not taken
    assign w_adv = !r_out_vld || o_res.ready;
    assign w_rep = (r_rep_cnt != '0);

    assign i_ref.ready = w_adv && !w_rep;
    assign w_acc       = i_ref.valid && i_ref.ready;

    assign w_eval     = (r_seen != CNT_W'(MAX_REFERENCE));
    assign w_seen_new = w_eval ? r_seen + CNT_W'(1) : r_seen;

    // replay feeds the oldest held base and rotates it back in at the top
    assign w_feed = (w_acc && w_eval) || (w_rep && w_adv);
    assign w_x    = w_rep ? r_win[0] : i_ref.base;

    always_comb begin
        w_tag.last      = i_ref.last;
        w_tag.score     = w_eval && (32'(w_seen_new) >= 32'(WINDOW));
        w_tag.short_ref = (32'(w_seen_new) < 32'(WINDOW));
        w_tag.start     = scbo_pkg::t_offset'(32'(w_seen_new) - 32'(WINDOW));
    end

    // cell chain: cell j adds base x times template base j
    assign w_sx[0]  = '0;
    assign w_sxx[0] = '0;
    assign w_sy[0]  = '0;
    assign w_sxy[0] = '0;

    for (genvar j = 0; j < WINDOW; j++) begin : g_cell
        scbo_cell #(
            .SX_W (SX_W),
            .SQ_W (SQ_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_feed),
            .i_x   (w_x),
            .i_y   (r_template[2*j +: 2]),
            .i_sx  (w_sx[j]),
            .i_sxx (w_sxx[j]),
            .i_sy  (w_sy[j]),
            .i_sxy (w_sxy[j]),
            .o_sx  (w_sx[j+1]),
            .o_sxx (w_sxx[j+1]),
            .o_sy  (w_sy[j+1]),
            .o_sxy (w_sxy[j+1])
        );
    end

    scbo_score #(
        .WINDOW (WINDOW),
        .SX_W   (SX_W),
        .SQ_W   (SQ_W)
    ) u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_vld        (r_a_vld),
        .i_tag        (r_a_tag),
        .i_sx         (w_sx[WINDOW]),
        .i_sxx        (w_sxx[WINDOW]),
        .i_sy         (w_sy[WINDOW]),
        .i_sxy        (w_sxy[WINDOW]),
        .o_rep_vld    (w_rep_vld),
        .o_rep_offset (w_rep_offset),
        .o_rep_status (w_rep_status)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_template <= '0;
            r_rep_cnt  <= '0;
            r_seen     <= '0;
            r_a_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_template <= i_cfg_data;
                r_rep_cnt  <= REP_W'(WINDOW - 1);
            end else if (w_rep && w_adv) begin
                r_rep_cnt  <= r_rep_cnt - REP_W'(1);
            end
            if (w_acc) begin
                r_seen <= i_ref.last ? '0 : w_seen_new;
            end
            if (w_adv) begin
                r_a_vld   <= w_acc;
                r_out_vld <= w_rep_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_feed) begin
            for (int i = 0; i < WINDOW - 2; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW-2] <= w_x;
        end
        if (w_adv) begin
            r_a_tag <= w_tag;
        end
        if (w_rep_vld) begin
            r_out_offset <= w_rep_offset;
            r_out_status <= w_rep_status;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.best_offset = r_out_offset;
    assign o_res.status      = r_out_status;

`ifndef SYNTHESIS
    // a template write always blocks input while the chain is rebuilt
    a_cfg_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_ref.ready)
        else $error("input accepted right after a template write");

    // the base count saturates at the reference limit
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(MAX_REFERENCE))
        else $error("base count beyond the reference limit");

    // a failed report never carries an offset
    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != scbo_pkg::STATUS_OK)) |->
            (o_res.best_offset == '0))
        else $error("nonzero offset on a failed report");
`endif

endmodule

`default_nettype wire

/* tb/scbo_board_pkg.sv */
// Scoreboard for the sliding correlation best-offset testbench: predicts the
// report of each reference from the accepted bases and checks reports in order.
// Depends on scbo_pkg for the payload types and status codes.

package scbo_board_pkg;
    import scbo_pkg::*;

    localparam int WIN       = 3;
    localparam int REF_LIMIT = 65536;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        t_offset offset;
        t_status status;
    } t_report;

    class best_offset_board;
        logic [2*WIN-1:0] tmpl;
        t_base            recent[WIN];   // oldest base at index 0
        int unsigned      base_count;
        int unsigned      lead_start;
        longint           lead_cov2;
        longint           lead_spread;
        bit               have_lead;
        t_report          reports_due[$];
        int               errors;

        function new();
            tmpl   = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (recent[i]) recent[i] = '0;
            base_count  = 0;
            lead_start  = 0;
            lead_cov2   = 0;
            lead_spread = 0;
            have_lead   = 1'b0;
        endfunction

        function void set_template(logic [2*WIN-1:0] v);
            tmpl = v;
        endfunction

        // Squared correlation kept as cov^2 / spread; template spread is common.
        function void rate_window(int unsigned start);
            longint sx, sxx, sy, syy, sxy, x, y, cov, xspread, yspread, cov2;
            sx  = 0;
            sxx = 0;
            sy  = 0;
            syy = 0;
            sxy = 0;
            for (int i = 0; i < WIN; i++) begin
                x = longint'(recent[i]);
                y = longint'(tmpl[2*i +: 2]);
                sx  += x;
                sxx += x * x;
                sy  += y;
                syy += y * y;
                sxy += x * y;
            end
            cov     = WIN * sxy - sx * sy;
            xspread = WIN * sxx - sx * sx;
            yspread = WIN * syy - sy * sy;
            if (cov == 0 || xspread <= 0 || yspread <= 0) return;
            cov2 = cov * cov;
            if (!have_lead || cov2 * lead_spread > lead_cov2 * xspread) begin
                have_lead   = 1'b1;
                lead_start  = start;
                lead_cov2   = cov2;
                lead_spread = xspread;
            end
        endfunction

        function void note_base(t_base b, logic lst);
            t_report rpt;
            if (base_count < REF_LIMIT) begin
                for (int i = 0; i < WIN - 1; i++) recent[i] = recent[i+1];
                recent[WIN-1] = b;
                base_count++;
                if (base_count >= WIN) rate_window(base_count - WIN);
            end
            if (!lst) return;
            if (base_count < WIN) begin
                rpt.offset = '0;
                rpt.status = STATUS_SHORT;
            end else if (!have_lead) begin
                rpt.offset = '0;
                rpt.status = STATUS_NONE;
            end else begin
                rpt.offset = lead_start[15:0];
                rpt.status = STATUS_OK;
            end
            reports_due.push_back(rpt);
            restart();
        endfunction

        function void check_report(t_offset o, t_status s);
            t_report want;
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected report: offset %0d status %0d", o, s);
                return;
            end
            want = reports_due.pop_front();
            if (o !== want.offset || s !== want.status) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("report mismatch: offset %0d status %0d, expected offset %0d status %0d",
                             o, s, want.offset, want.status);
            end
        endfunction
    endclass

endpackage

/* tb/tb_sliding_correlation_best_offset.sv */
// Top-level testbench for sliding_correlation_best_offset: drives reference
// streams and template writes, checks every report against the scoreboard.
// Depends on scbo_pkg, scbo_if, scbo_board_pkg and the block itself.

module tb_sliding_correlation_best_offset;
    import scbo_pkg::*;
    import scbo_board_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int RESET_CYCLES     = 5;
    localparam int SETTLE_CYCLES    = 8;        // covers the report latency, plus margin
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int RANDOM_PER_PHASE = 125;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [2*WIN-1:0] i_cfg_data;

    scbo_in_if  ref_if();
    scbo_out_if res_if();

    // Idle percentages for the sender and the receiver, changed per phase.
    int unsigned send_gap_pct = 31;
    int unsigned take_gap_pct = 74;
    int unsigned bases_sent   = 0;
    int unsigned tmpl_round   = 0;

    best_offset_board board;

    sliding_correlation_best_offset DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ref      (ref_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Receiver: ready drops at random in take_gap_pct of the cycles.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // Report monitor: signals read here hold their values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_report(res_if.best_offset, res_if.status);
        end
    end

    // One base. Called at a rising edge; returns at the edge that accepted it,
    // with valid still high so back-to-back items need no extra assignment.
    task automatic send_base(input t_base b, input logic lst);
        while ($urandom_range(99) < send_gap_pct) begin
            ref_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ref_if.valid <= 1'b1;
        ref_if.base  <= b;
        ref_if.last  <= lst;
        @(posedge i_clk);
        while (!ref_if.ready) @(posedge i_clk);
        board.note_base(b, lst);
        bases_sent++;
    endtask

    // A reference given as a digit string, e.g. "012"; last on the final digit.
    task automatic send_digits(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_base(t_base'(s[k] - 8'd48), k == s.len() - 1);
        end
    endtask

    // A reference of len bases: a flat run of flat_base first, random after.
    task automatic send_stream(input int unsigned len, input int unsigned flat_len,
                               input t_base flat_base);
        for (int unsigned k = 0; k < len; k++) begin
            send_base(k < flat_len ? flat_base : t_base'($urandom_range(3)), k == len - 1);
        end
    endtask

    // Sender holds off until every report has come, then gives the pipe time
    // to settle so a template write finds the block idle.
    task automatic drain_reports();
        ref_if.valid <= 1'b0;
        while (board.reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_template(input logic [2*WIN-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_template(v);
        i_cfg_we   <= 1'b0;
    endtask

    // Rounds of a few references each, with a new template per round. Every
    // third round takes an extreme (all-zero or all-ones, both constant).
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned len;
        int unsigned flat;
        stop_at = bases_sent + n_items;
        while (bases_sent < stop_at) begin
            drain_reports();
            if (tmpl_round % 3 == 0)
                write_template((tmpl_round / 3) % 2 ? '1 : '0);
            else
                write_template((2*WIN)'($urandom_range(63)));
            tmpl_round++;
            repeat ($urandom_range(3, 6)) begin
                // mostly full windows; some too short to score
                len  = ($urandom_range(99) < 15) ? $urandom_range(1, 2)
                                                 : $urandom_range(3, 12);
                // flat runs give zero-spread windows
                flat = ($urandom_range(99) < 20) ? $urandom_range(len) : 0;
                send_stream(len, flat, t_base'($urandom_range(3)));
            end
        end
    endtask

    initial begin
        board = new();
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        ref_if.valid <= 1'b0;
        ref_if.base  <= '0;
        ref_if.last  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the first idle profile.
        // Template after reset is all zero, so nothing can correlate.
        send_digits("012");
        drain_reports();
        write_template(6'b10_01_00);       // template bases 0,1,2
        send_digits("3");                  // single base: short reference
        send_digits("12");                 // one short of a window
        send_digits("012");                // perfect match at start 0
        send_digits("222");                // flat window: zero spread
        send_digits("3210123");            // anti-correlation and ties: first kept
        send_digits("103110");             // later window strictly better, then a tie

        run_random_phase(RANDOM_PER_PHASE);
        send_gap_pct = 74;
        take_gap_pct = 31;
        run_random_phase(RANDOM_PER_PHASE);
        send_gap_pct = 0;
        take_gap_pct = 0;
        run_random_phase(RANDOM_PER_PHASE);
        drain_reports();

        if (board.errors == 0) begin
            $display("tb_sliding_correlation_best_offset passed");
        end else begin
            $display("tb_sliding_correlation_best_offset failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_sliding_correlation_best_offset failed");
        $finish;
    end

endmodule
